/* design/saturating_integer_power_unit_assert.svh */
// ----------------------------------------------------------------------------
// Saturating integer power unit assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SATURATING_INTEGER_POWER_UNIT_ASSERT_SVH
`define SATURATING_INTEGER_POWER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sip_pkg.sv */
// ----------------------------------------------------------------------------
// Saturating integer power package
// Default widths shared by the unit, its submodules and its checker.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int DATA_BITS_DEF = 64;
  localparam int EXP_BITS_DEF  = 31;

endpackage

/* design/sip_mul.sv */
// ----------------------------------------------------------------------------
// Saturating integer power multiplier
// Shared unsigned multiplier: one half-width partial product per cycle,
// four per full product, with a flag for products above the max.
// ----------------------------------------------------------------------------
module sip_mul
  import sip_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DATA_BITS-1:0] a,
  input  logic [DATA_BITS-1:0] b,
  output logic                 done,
  output logic                 big,
  output logic [DATA_BITS-1:0] low
);

  localparam int H   = (DATA_BITS + 1) / 2;
  localparam int OPW = 2 * H;
  localparam int W   = 4 * H;

  logic [OPW-1:0] a_r;
  logic [OPW-1:0] b_r;
  logic [1:0]     step;
  logic           busy;
  logic [W-1:0]   accum;
  logic [H-1:0]   a_half;
  logic [H-1:0]   b_half;
  logic [OPW-1:0] pp;
  logic [W-1:0]   pp_ext;
  logic [W-1:0]   term;

  assign a_half = step[0] ? a_r[OPW-1:H] : a_r[H-1:0];
  assign b_half = step[1] ? b_r[OPW-1:H] : b_r[H-1:0];
  assign pp     = a_half * b_half;
  assign pp_ext = W'(pp);

  always_comb begin
    case (step) inside
      2'd0:       term = pp_ext;
      2'd1, 2'd2: term = pp_ext << H;
      default:    term = pp_ext << OPW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      a_r   <= OPW'(a);
      b_r   <= OPW'(b);
      accum <= '0;
      step  <= 2'd0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      accum <= accum + term;
      step  <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign big = |accum[W-1:DATA_BITS-1];
  assign low = accum[DATA_BITS-1:0];

endmodule

/* design/sip_core.sv */
// ----------------------------------------------------------------------------
// Saturating integer power sequencer
// Square-and-multiply control over the shared multiplier, sign fix-up,
// saturation and the output register.
// ----------------------------------------------------------------------------
module sip_core
  import sip_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int EXP_BITS  = EXP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_BITS-1:0] base_value,
  input  logic [EXP_BITS-1:0]  exponent,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] power_result,
  output logic                 overflowed,
  output logic                 mul_start,
  output logic [DATA_BITS-1:0] mul_a,
  output logic [DATA_BITS-1:0] mul_b,
  input  logic                 mul_done,
  input  logic                 mul_big,
  input  logic [DATA_BITS-1:0] mul_low
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ROUND    = 3'd1;
  localparam logic [2:0] ST_WAIT_ACC = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_WAIT_SQR = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  localparam logic [DATA_BITS-1:0] ONE     = DATA_BITS'(1);
  localparam logic [DATA_BITS-1:0] MAX_POS = {1'b0, {(DATA_BITS-1){1'b1}}};

  logic [2:0]           state;
  logic [DATA_BITS-1:0] mag;
  logic [DATA_BITS-1:0] acc;
  logic [EXP_BITS-1:0]  e;
  logic [EXP_BITS-1:0]  e_next;
  logic                 neg;
  logic                 odd;
  logic                 ovf;
  logic [DATA_BITS-1:0] mag_in;

  assign mag_in   = base_value[DATA_BITS-1] ? DATA_BITS'(~base_value + ONE) : base_value;
  assign e_next   = e >> 1;
  assign in_ready = (state == ST_IDLE);

  assign mul_start = ((state == ST_ROUND) && (e != '0) && e[0]) ||
                     ((state == ST_SHIFT) && (e_next != '0));
  assign mul_a     = (state == ST_SHIFT) ? mag : acc;
  assign mul_b     = mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            neg <= base_value[DATA_BITS-1];
            mag <= mag_in;
            e   <= exponent;
            odd <= exponent[0];
            ovf <= 1'b0;
            if (mag_in == '0) begin
              acc   <= (exponent == '0) ? ONE : '0;
              state <= ST_DONE;
            end else begin
              acc   <= ONE;
              state <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          if (e == '0) begin
            state <= ST_DONE;
          end else if (e[0]) begin
            state <= ST_WAIT_ACC;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_WAIT_ACC: begin
          if (mul_done) begin
            if (mul_big) begin
              ovf   <= 1'b1;
              state <= ST_DONE;
            end else begin
              acc   <= mul_low;
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          e <= e_next;
          state <= (e_next == '0) ? ST_DONE : ST_WAIT_SQR;
        end
        ST_WAIT_SQR: begin
          if (mul_done) begin
            if (mul_big) begin
              ovf   <= 1'b1;
              state <= ST_DONE;
            end else begin
              mag   <= mul_low;
              state <= ST_ROUND;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            overflowed   <= ovf;
            power_result <= ovf ? MAX_POS : ((neg && odd) ? DATA_BITS'(-acc) : acc);
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/saturating_integer_power_unit.sv */
// ----------------------------------------------------------------------------
// Saturating integer power unit
// Raises a signed base to a non-negative power by square-and-multiply,
// saturating to the largest positive value on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata; s_tdata carries the base
//   (DATA_BITS, signed) in the low bits and the exponent (EXP_BITS) above it.
//   Each item gives one result on m_tvalid/m_tready/m_tdata/m_tuser:
//   m_tdata is the signed power, m_tuser is set when it saturated.
//   One item is worked on at a time; s_tready is high only while the
//   sequencer is idle. Every multiply goes through one shared half-width
//   multiplier: it is issued, forms four partial products, then hands
//   the product back. A round (multiply into the accumulator for a set
//   bit, then square) runs once per exponent bit up to the highest set
//   bit; the last round does not square. An overflow ends the rounds
//   early, a zero exponent ends them at once and a zero base skips them.
//   s_tready rises in the same cycle that the result is registered.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the sequencer holds its next result
//   until that register frees. Reset drops any item in flight and clears
//   m_tvalid.
module saturating_integer_power_unit
  import sip_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int EXP_BITS  = EXP_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // fields from bit 0: base_value, exponent, zero fill
  input  logic [((DATA_BITS+EXP_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // fields from bit 0: power_result, zero fill
  output logic [((DATA_BITS+7)/8)*8-1:0]             m_tdata,
  // fields from bit 0: overflowed
  output logic                                       m_tuser
);

  logic [DATA_BITS-1:0] power_result;
  logic                 mul_start;
  logic [DATA_BITS-1:0] mul_a;
  logic [DATA_BITS-1:0] mul_b;
  logic                 mul_done;
  logic                 mul_big;
  logic [DATA_BITS-1:0] mul_low;

  sip_core #(
    .DATA_BITS(DATA_BITS),
    .EXP_BITS (EXP_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .base_value  (s_tdata[DATA_BITS-1:0]),
    .exponent    (s_tdata[DATA_BITS+EXP_BITS-1:DATA_BITS]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .power_result(power_result),
    .overflowed  (m_tuser),
    .mul_start   (mul_start),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_done    (mul_done),
    .mul_big     (mul_big),
    .mul_low     (mul_low)
  );

  sip_mul #(
    .DATA_BITS(DATA_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .big  (mul_big),
    .low  (mul_low)
  );

  assign m_tdata = (((DATA_BITS+7)/8)*8)'(power_result);

endmodule

/* design/sip_check.sv */
// ----------------------------------------------------------------------------
// Saturating integer power port checker
// Watches the unit's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "saturating_integer_power_unit_assert.svh"

module sip_check
  import sip_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((DATA_BITS+7)/8)*8-1:0]      m_tdata,
  input logic                                m_tuser
);

  localparam logic [DATA_BITS-1:0] MAX_POS = {1'b0, {(DATA_BITS-1){1'b1}}};

  `SIP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
  `SIP_ASSERT_NOW(a_sat_value, m_tvalid && m_tuser, m_tdata[DATA_BITS-1:0] == MAX_POS, "overflow flag without saturated value")
  `SIP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after an item was taken")

endmodule

bind saturating_integer_power_unit sip_check #(.DATA_BITS(DATA_BITS)) u_check (.*);

/* tb/saturating_integer_power_unit_tb.sv */
// ----------------------------------------------------------------------------
// Saturating integer power unit testbench
// Feeds directed corner cases and shaped random bases and exponents through
// the input stream, stalls both sides at random, and checks every result
// item and its overflow flag against a square-and-multiply power predictor.
// ----------------------------------------------------------------------------
module saturating_integer_power_unit_tb
  import sip_pkg::*;
;

  localparam int DW      = DATA_BITS_DEF;
  localparam int EW      = EXP_BITS_DEF;
  localparam int S_WIDTH = ((DW + EW + 7) / 8) * 8;
  localparam int M_WIDTH = ((DW + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 3 + 12 * EW + 40;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 1875;

  localparam logic [DW-1:0] MAX_POS  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [EW-1:0] MAX_EXP  = {EW{1'b1}};

  typedef struct packed {
    logic [DW-1:0] base_value;
    logic [EW-1:0] exponent;
  } power_request_t;

  typedef struct packed {
    logic [DW-1:0] power_result;
    logic          overflowed;
  } power_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [S_WIDTH-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [M_WIDTH-1:0] m_tdata;
  logic               m_tuser;

  power_request_t request_q[$];
  power_answer_t  expected_power_q[$];
  int             mismatch_count = 0;
  int             send_gap = 0;
  int             ready_hold = 0;
  logic           steady_mode = 1'b0;
  power_request_t next_request;
  power_answer_t  got_answer;
  power_answer_t  want_answer;
  int             stall;

  saturating_integer_power_unit #(
    .DATA_BITS(DW),
    .EXP_BITS (EW)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic power_answer_t saturating_power(input logic [DW-1:0] base_in,
                                                     input logic [EW-1:0] exp_in);
    power_answer_t ans;
    logic [DW-1:0] mag;
    logic [DW-1:0] acc;
    logic [EW-1:0] e;
    logic          negative;
    logic          sat;
    negative = base_in[DW-1];
    mag = negative ? -base_in : base_in;
    acc = 1;
    e = exp_in;
    sat = 1'b0;
    if (mag == 0) begin
      ans.power_result = (exp_in == 0) ? 1 : 0;
      ans.overflowed = 1'b0;
    end else begin
      while (e != 0 && !sat) begin
        if (e[0]) begin
          if (acc > MAX_POS / mag) sat = 1'b1;
          else acc = acc * mag;
        end
        e = e >> 1;
        if (!sat && e != 0) begin
          if (mag > MAX_POS / mag) sat = 1'b1;
          else mag = mag * mag;
        end
      end
      ans.overflowed = sat;
      if (sat) ans.power_result = MAX_POS;
      else ans.power_result = (negative && exp_in[0]) ? -acc : acc;
    end
    return ans;
  endfunction

  function automatic int idle_cycles(input int stall_pct);
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r >= stall_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DW-1:0] signed_value(input logic [DW-1:0] mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic add_request(input logic [DW-1:0] b, input logic [EW-1:0] e);
    power_request_t req;
    req.base_value = b;
    req.exponent = e;
    request_q.push_back(req);
  endtask

  task automatic add_random_request();
    int            pick;
    int            k;
    logic [DW-1:0] mag;
    logic [DW-1:0] full;
    logic [EW-1:0] e;
    pick = $urandom_range(0, 99);
    full = {$urandom, $urandom};
    e = $urandom;
    if (pick < 40) begin
      k = $urandom_range(1, DW - 1);
      mag = (full >> (DW - k)) | (64'd1 << (k - 1));
      add_request(signed_value(mag), $urandom_range(1, (DW - 1) / k + 1));
    end else if (pick < 55) begin
      add_request(signed_value($urandom_range(1, 3)), ($urandom_range(0, 3) == 0) ? e : e >> 20);
    end else if (pick < 70) begin
      add_request(full, $urandom_range(0, 3));
    end else if (pick < 85) begin
      add_request(full, e);
    end else if (pick < 93) begin
      add_request('0, $urandom_range(0, 1) ? e : '0);
    end else begin
      add_request(full >> $urandom_range(0, DW - 1), '0);
    end
  endtask

  // driver: present the next pending item once the previous one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_q.size() > 0) begin
        next_request = request_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_WIDTH - DW - EW){1'b0}}, next_request.exponent,
                    next_request.base_value};
        send_gap <= idle_cycles(50);
        if ($urandom_range(0, 99) < 3) steady_mode <= ~steady_mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      stall = idle_cycles(20);
      m_tready <= (stall == 0);
      ready_hold <= (stall > 0) ? stall - 1 : 0;
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_power_q.push_back(saturating_power(s_tdata[DW-1:0], s_tdata[DW+EW-1:DW]));
      if (m_tvalid && m_tready) begin
        got_answer.power_result = m_tdata[DW-1:0];
        got_answer.overflowed = m_tuser;
        if (expected_power_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result item: power %h overflow %b",
                     got_answer.power_result, got_answer.overflowed);
        end else begin
          want_answer = expected_power_q.pop_front();
          if (got_answer.power_result !== want_answer.power_result ||
              got_answer.overflowed !== want_answer.overflowed) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: power exp %h got %h, overflow exp %b got %b",
                       want_answer.power_result, got_answer.power_result,
                       want_answer.overflowed, got_answer.overflowed);
          end
        end
      end
    end
  end

  initial begin
    add_request('0, '0);
    add_request('0, 1);
    add_request('0, MAX_EXP);
    add_request(64'd5, '0);
    add_request(-64'd5, '0);
    add_request(MAX_POS, '0);
    add_request(MAX_POS, 1);
    add_request(-MAX_POS, 1);
    add_request(MAX_POS, 2);
    add_request(MOST_NEG, '0);
    add_request(MOST_NEG, 1);
    add_request(MOST_NEG, 2);
    add_request(64'd1, MAX_EXP);
    add_request(-64'd1, MAX_EXP);
    add_request(-64'd1, MAX_EXP - 1);
    add_request(64'd2, 62);
    add_request(64'd2, 63);
    add_request(-64'd2, 63);
    add_request(-64'd2, 62);
    add_request(64'd3, 39);
    add_request(-64'd3, 39);
    add_request(64'd3, 40);
    add_request(64'd3037000499, 2);
    add_request(64'd3037000500, 2);
    for (int i = 0; i < RANDOM_ITEMS; i++) add_random_request();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (request_q.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_power_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_power_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
